// ----- rtl/core/brent_hash_insert_macros.svh -----
// assertion macros for the brent hash insert block
`ifndef BRENT_HASH_INSERT_MACROS_SVH
`define BRENT_HASH_INSERT_MACROS_SVH
`define BHI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BHI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/bhi_pkg.sv -----
// ------------------------------------------------------------------
// bhi_pkg
// shared constants and types for the brent hash insert block
// ------------------------------------------------------------------
package bhi_pkg;
    localparam int TableSize = 9371;
    localparam int IdxW = 14;
    localparam int KeyW = 31;
    localparam int QuotW = 18;
    localparam logic [IdxW-1:0] TABLE_SIZE_C = 14'(TableSize);
    localparam logic [13:0] PROBE_LIMIT_RST = 14'd9371;
    localparam logic [1:0] ST_HOME  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_MOVED = 2'd2;
    localparam logic [1:0] ST_FAIL  = 2'd3;

    // reciprocals of the table size: key / size = (key * RECIP_KEY) >> 45 for
    // 31-bit keys, quot / size = (quot * RECIP_QUOT) >> 32 for 18-bit quotients
    localparam logic [31:0] RECIP_KEY  = 32'd3754601653;
    localparam logic [18:0] RECIP_QUOT = 19'd458326;

    // classified item handed from front to back
    typedef struct packed {
        logic [KeyW-1:0] key;
        logic [IdxW-1:0] home;
        logic [IdxW-1:0] step;
        logic            zero;
    } job_t;

    // a mod TableSize for a < 2*TableSize
    function automatic logic [IdxW-1:0] wrap(input logic [IdxW:0] a);
        logic [IdxW:0] d;
        d = a - {1'b0, TABLE_SIZE_C};
        return (a >= {1'b0, TABLE_SIZE_C}) ? d[IdxW-1:0] : a[IdxW-1:0];
    endfunction
endpackage

// ----- rtl/core/brent_hash_insert.sv -----
// ------------------------------------------------------------------
// brent_hash_insert
// open-addressed hash insert with brent relocation of the home occupant
// ------------------------------------------------------------------
// channel     dir  fields (tdata low bit up)
// s_axis      in   key[30:0]
// m_axis      out  status[1:0] slot[15:2] moved_slot[29:16] probes[43:30]
// cfg         in   probe_limit[13:0]
// front: an accepted key becomes a job, home slot and step by reciprocal multiply
// back: a free home slot or zero key is answered from the home read; a collision adds the
//   occupant step, a read and a check state per slot on each search and the write states WR1, WR2
// after reset the table clears every slot before the back takes its first job
// a one-entry job register between front and back lets them stall apart
module brent_hash_insert
    import bhi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [13:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status, slot, moved_slot, probes
);
    logic [13:0] limit_reg;
    logic        jv, jr;
    job_t        jb;
    logic [1:0]  st;
    logic [IdxW-1:0] sl, mv, pr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= PROBE_LIMIT_RST;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    bhi_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_key(s_axis_tdata[KeyW-1:0]), .job_valid(jv), .job_ready(jr), .job(jb)
    );

    bhi_back u_back (
        .clk(clk), .rst_n(rst_n), .probe_limit(limit_reg), .job_valid(jv),
        .job_ready(jr), .job(jb), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .res_status(st), .res_slot(sl), .res_moved(mv), .res_probes(pr)
    );

    assign m_axis_tdata = {4'b0, pr, mv, sl, st};
endmodule

// ----- rtl/core/bhi_divmod.sv -----
// ------------------------------------------------------------------
// bhi_divmod
// home slot and step of a key by reciprocal multiplies
// ------------------------------------------------------------------
module bhi_divmod
    import bhi_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [KeyW-1:0] dividend,
    output logic            done,
    output logic [IdxW-1:0] quot_step,
    output logic [IdxW-1:0] rem
);
    logic [KeyW-1:0]  dvd_reg;
    logic [QuotW-1:0] q_reg;
    logic [QuotW-1:0] qh_reg;
    logic [4:0]       q2_reg;
    logic [IdxW-1:0]  rem_reg;
    logic [IdxW-1:0]  step_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             done_reg;
    logic [62:0]      prod1;
    logic [36:0]      prod2;
    logic [31:0]      qm;
    logic [KeyW-1:0]  remw;
    logic [QuotW-1:0] q2m;
    logic [QuotW-1:0] stepw;

    // quotient of the key, below 2^18
    assign prod1 = 63'(dividend) * 63'(RECIP_KEY);
    // key minus quotient times size gives the home slot
    assign qm = 32'(q_reg) * 32'(TABLE_SIZE_C);
    assign remw = dvd_reg - qm[KeyW-1:0];
    // quotient of the quotient, at most 24
    assign prod2 = 37'(q_reg) * 37'(RECIP_QUOT);
    assign q2m = 18'(q2_reg) * 18'(TABLE_SIZE_C);
    assign stepw = qh_reg - q2m;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            q_reg <= prod1[62:45];
        end
        if (v1_reg)
        begin
            rem_reg <= remw[IdxW-1:0];
            q2_reg <= prod2[36:32];
            qh_reg <= q_reg;
        end
        if (v2_reg)
            step_reg <= (qh_reg == '0) ? 14'd1 : stepw[IdxW-1:0];
    end

    // step is the quotient taken mod table size, at least 1 for a zero quotient
    assign done = done_reg;
    assign rem = rem_reg;
    assign quot_step = step_reg;
endmodule

// ----- rtl/core/bhi_front.sv -----
// ------------------------------------------------------------------
// bhi_front
// takes keys, computes home slot and step, holds each job until the back takes it
// ------------------------------------------------------------------
module bhi_front
    import bhi_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [KeyW-1:0] in_key,
    output logic            job_valid,
    input  logic            job_ready,
    output job_t            job
);
    typedef enum logic [1:0] {F_IDLE, F_DIV, F_OUT} fstate_t;
    fstate_t st_reg;
    job_t    job_reg;
    logic    dstart;
    logic    ddone;
    logic [IdxW-1:0] dqs, drem;

    assign in_ready = (st_reg == F_IDLE);
    assign dstart = in_valid && in_ready;
    assign job_valid = (st_reg == F_OUT);
    assign job = job_reg;

    bhi_divmod u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(in_key),
        .done(ddone), .quot_step(dqs), .rem(drem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= F_IDLE;
        else
        begin
            case (st_reg)
                F_IDLE:
                    if (dstart)
                        st_reg <= F_DIV;
                F_DIV:
                    if (ddone)
                        st_reg <= F_OUT;
                F_OUT:
                    if (job_ready)
                        st_reg <= F_IDLE;
                default:
                    st_reg <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            F_IDLE:
                if (dstart)
                begin
                    job_reg.key <= in_key;
                    job_reg.zero <= (in_key == '0);
                end
            F_DIV:
                if (ddone)
                begin
                    job_reg.home <= drem;
                    job_reg.step <= dqs;
                end
            default:
            begin
            end
        endcase
    end
endmodule

// ----- rtl/core/bhi_back.sv -----
// ------------------------------------------------------------------
// bhi_back
// table memory and probe sequencer for the two brent searches
// ------------------------------------------------------------------
module bhi_back
    import bhi_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [13:0]     probe_limit,
    input  logic            job_valid,
    output logic            job_ready,
    input  job_t            job,
    output logic            res_valid,
    input  logic            res_ready,
    output logic [1:0]      res_status,
    output logic [IdxW-1:0] res_slot,
    output logic [IdxW-1:0] res_moved,
    output logic [IdxW-1:0] res_probes
);
    typedef enum logic [3:0] {
        B_CLEAR, B_IDLE, B_RDHOME, B_CHKHOME, B_OCCDIV,
        B_S1RD, B_S1CHK, B_S2RD, B_S2CHK, B_WR1, B_WR2, B_OUT
    } bstate_t;

    logic [KeyW-1:0] mem [TableSize];
    logic [KeyW-1:0] rd_reg;
    logic [IdxW-1:0] raddr;
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [KeyW-1:0] wdata;

    bstate_t st_reg;
    job_t    j_reg;
    logic [KeyW-1:0] occ_reg;
    logic [IdxW-1:0] ostep_reg, pos_reg, p1_reg, c1_reg, n_reg;
    logic            ok1_reg;
    logic [1:0]      status_reg;
    logic [IdxW-1:0] slot_reg, moved_reg, probes_reg;
    logic [IdxW-1:0] clr_reg;
    logic            dstart, ddone;
    logic [IdxW-1:0] dqs, drem;
    logic [IdxW-1:0] nextpos;
    logic [IdxW-1:0] curstep;

    assign job_ready = (st_reg == B_IDLE);
    assign res_valid = (st_reg == B_OUT);
    assign res_status = status_reg;
    assign res_slot = slot_reg;
    assign res_moved = moved_reg;
    assign res_probes = probes_reg;

    // occupant is taken straight from the home read
    bhi_divmod u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(rd_reg),
        .done(ddone), .quot_step(dqs), .rem(drem)
    );
    assign dstart = (st_reg == B_CHKHOME) && !j_reg.zero && (rd_reg != '0);

    assign curstep = (st_reg == B_S1CHK || st_reg == B_S1RD) ? ostep_reg : j_reg.step;
    assign nextpos = wrap({1'b0, pos_reg} + {1'b0, curstep});

    always_comb
    begin
        raddr = pos_reg;
        if (st_reg == B_RDHOME)
            raddr = j_reg.home;
        we = 1'b0;
        waddr = pos_reg;
        wdata = j_reg.key;
        case (st_reg)
            B_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg;
                wdata = '0;
            end
            B_CHKHOME:
                if (!j_reg.zero && rd_reg == '0)
                begin
                    we = 1'b1;
                    waddr = j_reg.home;
                end
            B_WR1:
                if (status_reg == ST_MOVED)
                begin
                    we = 1'b1;
                    waddr = p1_reg;
                    wdata = occ_reg;
                end
                else if (status_reg == ST_PROBE)
                begin
                    we = 1'b1;
                    waddr = slot_reg;
                end
            B_WR2:
                if (status_reg == ST_MOVED)
                begin
                    we = 1'b1;
                    waddr = j_reg.home;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= B_CLEAR;
            clr_reg <= '0;
        end
        else
        begin
            case (st_reg)
                B_CLEAR:
                begin
                    clr_reg <= clr_reg + 14'd1;
                    if (clr_reg == TABLE_SIZE_C - 14'd1)
                        st_reg <= B_IDLE;
                end
                B_IDLE:
                    if (job_valid)
                    begin
                        j_reg <= job;
                        st_reg <= B_RDHOME;
                    end
                B_RDHOME:
                    st_reg <= B_CHKHOME;
                B_CHKHOME:
                begin
                    occ_reg <= rd_reg;
                    slot_reg <= j_reg.home;
                    moved_reg <= '0;
                    probes_reg <= '0;
                    if (j_reg.zero)
                    begin
                        status_reg <= ST_FAIL;
                        slot_reg <= '0;
                        st_reg <= B_OUT;
                    end
                    else if (rd_reg == '0)
                    begin
                        status_reg <= ST_HOME;
                        st_reg <= B_OUT;
                    end
                    else
                        st_reg <= B_OCCDIV;
                end
                B_OCCDIV:
                    if (ddone)
                    begin
                        ostep_reg <= dqs;
                        pos_reg <= wrap({1'b0, j_reg.home} + {1'b0, dqs});
                        n_reg <= '0;
                        st_reg <= B_S1RD;
                    end
                B_S1RD:
                    st_reg <= B_S1CHK;
                B_S1CHK:
                    if (rd_reg == '0 || n_reg >= probe_limit)
                    begin
                        ok1_reg <= (rd_reg == '0);
                        p1_reg <= pos_reg;
                        c1_reg <= n_reg;
                        pos_reg <= wrap({1'b0, j_reg.home} + {1'b0, j_reg.step});
                        n_reg <= '0;
                        st_reg <= B_S2RD;
                    end
                    else
                    begin
                        pos_reg <= nextpos;
                        n_reg <= n_reg + 14'd1;
                        st_reg <= B_S1RD;
                    end
                B_S2RD:
                    st_reg <= B_S2CHK;
                B_S2CHK:
                    if (rd_reg == '0 || n_reg >= probe_limit)
                    begin
                        if (ok1_reg && (rd_reg != '0 || c1_reg < n_reg))
                        begin
                            status_reg <= ST_MOVED;
                            moved_reg <= p1_reg;
                            probes_reg <= c1_reg;
                        end
                        else if (rd_reg == '0)
                        begin
                            status_reg <= ST_PROBE;
                            slot_reg <= pos_reg;
                            probes_reg <= n_reg;
                        end
                        else
                        begin
                            status_reg <= ST_FAIL;
                            slot_reg <= '0;
                            probes_reg <= probe_limit;
                        end
                        st_reg <= B_WR1;
                    end
                    else
                    begin
                        pos_reg <= nextpos;
                        n_reg <= n_reg + 14'd1;
                        st_reg <= B_S2RD;
                    end
                B_WR1:
                    st_reg <= B_WR2;
                B_WR2:
                    st_reg <= B_OUT;
                B_OUT:
                    if (res_ready)
                        st_reg <= B_IDLE;
                default:
                    st_reg <= B_IDLE;
            endcase
        end
    end

`include "brent_hash_insert_macros.svh"
    `BHI_ASSERT_IMP(a_home_ok, res_valid && res_status == ST_HOME, res_probes == '0)
    `BHI_ASSERT_IMP(a_slot_rng, res_valid, res_slot < TABLE_SIZE_C)
    `BHI_ASSERT_NEXT(a_out_hold, res_valid && !res_ready, res_valid)
endmodule

// ----- dv/brent_hash_insert_checker.sv -----
`timescale 1ns / 100ps
// ------------------------------------------------------------------
// brent_hash_insert_checker
// watches key and result words, models the hash table and compares
// ------------------------------------------------------------------
module brent_hash_insert_checker
    import bhi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [13:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    output int          fail_count,
    output int          pending,
    output int          n_results,
    output int          n_moved,
    output int          n_full
);
    typedef struct packed {
        logic [1:0]      status;
        logic [IdxW-1:0] slot;
        logic [IdxW-1:0] moved_slot;
        logic [IdxW-1:0] probes;
    } placement_t;

    logic [KeyW-1:0] table_model [TableSize];
    logic [13:0]     limit_model;
    placement_t      placements [$];

    function automatic int unsigned key_step(input logic [KeyW-1:0] k);
        int unsigned s;
        s = k / TableSize;
        return (s == 0) ? 1 : s;
    endfunction

    // returns 1 when an empty slot is found
    function automatic bit walk(input int unsigned home, input int unsigned step,
                                output int unsigned where, output int unsigned cnt);
        longint unsigned pos;
        pos = (longint'(home) + step) % TableSize;
        cnt = 0;
        while (table_model[pos] != 0)
        begin
            if (cnt >= limit_model)
            begin
                where = pos;
                return 0;
            end
            pos = (pos + step) % TableSize;
            cnt++;
        end
        where = pos;
        return 1;
    endfunction

    function automatic placement_t place_key(input logic [KeyW-1:0] k);
        placement_t  r;
        int unsigned home, p1, c1, p2, c2;
        logic [KeyW-1:0] occ;
        bit ok1, ok2, move_occ;
        r = '{status: ST_FAIL, slot: '0, moved_slot: '0, probes: '0};
        if (k == 0)
            return r;
        home = k % TableSize;
        if (table_model[home] == 0)
        begin
            table_model[home] = k;
            r.status = ST_HOME;
            r.slot = IdxW'(home);
            return r;
        end
        occ = table_model[home];
        ok1 = walk(home, key_step(occ), p1, c1);
        ok2 = walk(home, key_step(k), p2, c2);
        move_occ = (ok1 && ok2) ? (c1 < c2) : ok1;
        if (!ok1 && !ok2)
            r.probes = limit_model;
        else if (move_occ)
        begin
            table_model[p1] = occ;
            table_model[home] = k;
            r.status = ST_MOVED;
            r.slot = IdxW'(home);
            r.moved_slot = IdxW'(p1);
            r.probes = IdxW'(c1);
        end
        else
        begin
            table_model[p2] = k;
            r.status = ST_PROBE;
            r.slot = IdxW'(p2);
            r.probes = IdxW'(c2);
        end
        return r;
    endfunction

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    assign pending = placements.size();

    always @(posedge clk or negedge rst_n)
    begin
        placement_t got, want;
        if (!rst_n)
        begin
            foreach (table_model[i]) table_model[i] = '0;
            limit_model = PROBE_LIMIT_RST;
            placements.delete();
            fail_count = 0;
            n_results = 0;
            n_moved = 0;
            n_full = 0;
        end
        else
        begin
            if (cfg_we)
                limit_model = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                placements.push_back(place_key(s_axis_tdata[KeyW-1:0]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tdata[1:0];
                got.slot = m_axis_tdata[15:2];
                got.moved_slot = m_axis_tdata[29:16];
                got.probes = m_axis_tdata[43:30];
                n_results++;
                if (placements.size() == 0)
                    report("unexpected word", got.status, 0);
                else
                begin
                    want = placements.pop_front();
                    if (want.status == ST_MOVED) n_moved++;
                    if (want.status == ST_FAIL) n_full++;
                    if (got.status != want.status) report("status", got.status, want.status);
                    if (got.slot != want.slot) report("slot", got.slot, want.slot);
                    if (got.moved_slot != want.moved_slot)
                        report("moved_slot", got.moved_slot, want.moved_slot);
                    if (got.probes != want.probes) report("probes", got.probes, want.probes);
                end
            end
        end
    end
endmodule

// ----- dv/tb_brent_hash_insert.sv -----
`timescale 1ns / 100ps
// ------------------------------------------------------------------
// tb_brent_hash_insert
// drives keys and probe limits with random idling; checker verifies placement
// ------------------------------------------------------------------
module tb_brent_hash_insert;
    import bhi_pkg::*;

    // the watchdog limit is well above two full searches at the widest limit
    localparam int WatchLimit = 300000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [13:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // key[30:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [47:0] m_axis_tdata;        // status, slot, moved_slot, probes
    int          fail_count, pending, n_results, n_moved, n_full;
    int          idle_pct = 28;
    int          quiet_cycles = 0;

    always #5 clk = ~clk;

    brent_hash_insert i_dut (.*);
    brent_hash_insert_checker i_chk (.*);

    // result side stalls at random
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit)
        begin
            $display("watchdog expired, %0d results outstanding", pending);
            $display("tb_brent_hash_insert: done, errors");
            $finish;
        end
    end

    // valid stays up after the word so back to back words need no gap
    task automatic send_key(input logic [30:0] k);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {1'b0, k};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_limit(input logic [13:0] v);
        s_axis_tvalid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // keys sharing one home slot, clustered to force collisions
    function automatic logic [30:0] clustered_key(input int unsigned home);
        logic [30:0] k;
        k = 31'(longint'($urandom_range(229000)) * TableSize + home);
        return (k == 0) ? 31'(home + TableSize) : k;
    endfunction

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1;
        // directed: extremes, home, collision, step a table multiple, zero key
        send_key(31'd1);
        send_key(31'h7FFF_FFFF);
        send_key(31'h2AAA_AAAA);
        send_key(31'h5555_5555);
        send_key(31'd9370);
        send_key(31'd9371);
        send_key(31'd18742);
        send_key(31'd1 + 31'd9371);
        send_key(31'd1 + 31'd2 * 9371);
        send_key(31'(9371 * 9371 + 5));
        send_key(31'(9371 * 9371 * 2 + 5));
        send_key(31'd5);
        send_key(31'd0);
        send_key(31'd1);
        set_limit(14'd0);
        send_key(31'd1 + 31'd3 * 9371);
        send_key(31'd5 + 31'd9371);
        send_key(31'd0);
        set_limit(14'd1);
        send_key(31'd1 + 31'd4 * 9371);
        send_key(31'd9370 + 31'd9371);
        // random phases over several limits, one without idling
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_limit(14'h3FFF);
                1: set_limit(14'($urandom_range(2, 40)));
                2: set_limit(14'd9371);
                3: set_limit(14'd3);
                default: set_limit(14'($urandom_range(16383)));
            endcase
            idle_pct = (ph == 2) ? 0 : 28;
            for (int i = 0; i < 270; i++)
            begin
                if ($urandom_range(99) < 60)
                    send_key(clustered_key($urandom_range(40)));
                else if ($urandom_range(99) < 3)
                    send_key(31'd0);
                else
                    send_key(31'($urandom));
            end
        end
        s_axis_tvalid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        $display("%0d results checked, %0d occupant moves, %0d failed inserts",
                 n_results, n_moved, n_full);
        $display("probe limits swept from 0 to 16383 with clustered and random keys");
        if (fail_count == 0)
            $display("tb_brent_hash_insert: done, clean");
        else
            $display("tb_brent_hash_insert: done, errors");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/bhi_pkg.sv
rtl/core/bhi_divmod.sv
rtl/core/bhi_front.sv
rtl/core/bhi_back.sv
rtl/core/brent_hash_insert.sv
dv/brent_hash_insert_checker.sv
dv/tb_brent_hash_insert.sv
